### design/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Used by ple_cell and positional_list_engine; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    localparam int DATA_W      = 32;
    localparam int MODE_W      = 3;
    localparam int POS_W       = 6;
    localparam int FIDX_W      = 5;
    localparam int CNT_W       = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int RES_W       = 1 + DATA_W + FIDX_W + CNT_W;
    localparam int OUT_TDATA_W = 48;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

    typedef struct packed {
        logic ins;
        logic set;
        logic rem;
        logic find;
    } t_cell_ctl;

endpackage

`default_nettype wire

### design/ple_cell.sv
// One list position: value register plus a stage of the result carry chain.
// Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell #(
    parameter int IDX = 0,
    parameter int PW  = 6,
    parameter int IW  = 5
) (
    input  wire                          i_clk,
    input  ple_pkg::t_cell_ctl           i_ctl,
    input  wire  [PW-1:0]                i_pos,
    input  wire  [PW-1:0]                i_count,
    input  wire  [ple_pkg::DATA_W-1:0]   i_value,
    input  wire  [ple_pkg::DATA_W-1:0]   i_left,
    input  wire  [ple_pkg::DATA_W-1:0]   i_right,
    output logic [ple_pkg::DATA_W-1:0]   o_val,
    input  wire                          i_c_valid,
    input  wire  [ple_pkg::DATA_W-1:0]   i_c_data,
    input  wire  [IW-1:0]                i_c_idx,
    output logic                         o_c_valid,
    output logic [ple_pkg::DATA_W-1:0]   o_c_data,
    output logic [IW-1:0]                o_c_idx
);

    localparam logic [PW-1:0] L_POS = PW'(IDX);
    localparam logic [IW-1:0] L_IDX = IW'(IDX);

    logic [ple_pkg::DATA_W-1:0] r_val;
    logic [ple_pkg::DATA_W-1:0] n_val;
    logic                       w_hit;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (L_POS > i_pos) begin
                n_val = i_left;
            end else if (L_POS == i_pos) begin
                n_val = i_value;
            end
        end
        if (i_ctl.set && (L_POS == i_pos)) begin
            n_val = i_value;
        end
        if (i_ctl.rem && (L_POS >= i_pos)) begin
            n_val = i_right;
        end
    end

    // find: value match inside the list; get/remove: position match
    assign w_hit = i_ctl.find ? ((r_val == i_value) && (L_POS < i_count)) : (L_POS == i_pos);

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        o_c_valid <= i_c_valid | w_hit;
        o_c_data  <= i_c_valid ? i_c_data : r_val;
        o_c_idx   <= i_c_valid ? i_c_idx : L_IDX;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

### design/positional_list_engine.sv
// Positional list engine top level: control sequencer, cell chain, output register.
// Depends on ple_pkg and ple_cell.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit words in a row of cells. Insert,
// set, clear and unused modes pass through the execute and finish states to the output
// register; get, find and remove also wait in the scan state for the result carry chain,
// which moves one cell per clock towards the tail. One item is in work at a time; the
// next is accepted once the result sits in the output register, even if not yet taken.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // tuser: mode[2:0]
    input  wire  [ple_pkg::MODE_W-1:0]         i_s_tuser,
    // tdata: index[5:0], value[37:6], zero fill[39:38]
    input  wire  [ple_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // tdata: ok[0], read_value[32:1], found_index[37:33], item_count[43:38], zero[47:44]
    output logic [ple_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
    localparam int DW = ple_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [ple_pkg::MODE_W-1:0]  r_mode, n_mode;
    logic [ple_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [DW-1:0]               r_value, n_value;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_scan, n_scan;
    logic [ple_pkg::RES_W-1:0]   r_res, n_res;
    logic                        r_out_valid, n_out_valid;
    logic [ple_pkg::RES_W-1:0]   r_out_data, n_out_data;

    ple_pkg::t_cell_ctl          w_ctl;
    logic [PW-1:0]               w_pos;
    logic [PW-1:0]               w_cnt;
    logic [PW-1:0]               w_ncnt;
    logic [PW-1:0]               w_tidx;
    logic                        w_pos_lt;
    logic                        w_ins_ok;
    logic                        w_accept;
    logic                        r_ok, w_ok;
    logic [DW-1:0]               w_rd;
    logic [ple_pkg::FIDX_W-1:0]  w_fidx;

    logic [DW-1:0]               w_val [CAPACITY];
    logic                        w_cv  [CAPACITY];
    logic [DW-1:0]               w_cd  [CAPACITY];
    logic [IW-1:0]               w_ci  [CAPACITY];

    assign w_pos    = PW'(r_pos);
    assign w_cnt    = PW'(r_count);
    assign w_ncnt   = PW'(n_count);
    assign w_tidx   = PW'(w_ci[CAPACITY-1]);
    assign w_pos_lt = (w_pos < w_cnt);
    assign w_ins_ok = (w_pos <= w_cnt) && (w_cnt < PW'(CAPACITY));
    assign w_accept = i_s_tvalid && o_s_tready;
    assign r_ok     = r_res[0];

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(ple_pkg::OUT_TDATA_W - ple_pkg::RES_W){1'b0}}, r_out_data};

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_value     = r_value;
        n_count     = r_count;
        n_scan      = r_scan;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        w_ctl       = '0;
        w_ctl.find  = (r_mode == ple_pkg::MODE_FIND);
        w_ok        = 1'b0;
        w_rd        = '0;
        w_fidx      = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_s_tuser;
                    n_pos   = i_s_tdata[ple_pkg::POS_W-1:0];
                    n_value = i_s_tdata[ple_pkg::POS_W +: DW];
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_scan  = CW'(1);
                n_state = ST_FIN;
                case (r_mode)
                    ple_pkg::MODE_INSERT: begin
                        if (w_ins_ok) begin
                            w_ctl.ins = 1'b1;
                            n_count   = r_count + CW'(1);
                            w_ok      = 1'b1;
                        end
                    end
                    ple_pkg::MODE_SET: begin
                        if (w_pos_lt) begin
                            w_ctl.set = 1'b1;
                            w_ok      = 1'b1;
                        end
                    end
                    ple_pkg::MODE_CLEAR: begin
                        n_count = '0;
                        w_ok    = 1'b1;
                    end
                    ple_pkg::MODE_GET,
                    ple_pkg::MODE_REMOVE,
                    ple_pkg::MODE_FIND: begin
                        n_state = ST_SCAN;
                    end
                    default: begin
                        w_ok = 1'b0;
                    end
                endcase
                n_res = {w_ncnt[ple_pkg::CNT_W-1:0], w_fidx, w_rd, w_ok};
            end
            ST_SCAN: begin
                if (r_scan == CW'(CAPACITY)) begin
                    n_state = ST_FIN;
                    case (r_mode)
                        ple_pkg::MODE_GET: begin
                            w_ok = w_pos_lt;
                            w_rd = w_pos_lt ? w_cd[CAPACITY-1] : '0;
                        end
                        ple_pkg::MODE_REMOVE: begin
                            if (w_pos_lt) begin
                                w_ok      = 1'b1;
                                w_rd      = w_cd[CAPACITY-1];
                                w_ctl.rem = 1'b1;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        ple_pkg::MODE_FIND: begin
                            w_ok   = w_cv[CAPACITY-1];
                            w_fidx = w_cv[CAPACITY-1] ? w_tidx[ple_pkg::FIDX_W-1:0] : '0;
                        end
                        default: begin
                            w_ok = 1'b0;
                        end
                    endcase
                    n_res = {w_ncnt[ple_pkg::CNT_W-1:0], w_fidx, w_rd, w_ok};
                end else begin
                    n_scan = r_scan + CW'(1);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_pos      <= n_pos;
        r_value    <= n_value;
        r_scan     <= n_scan;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // cell chain: values shift between neighbours, results carry towards the tail
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;
        logic          w_civ;
        logic [DW-1:0] w_cid;
        logic [IW-1:0] w_cii;

        if (g == 0) begin : g_head
            assign w_left = r_value;
            assign w_civ  = 1'b0;
            assign w_cid  = '0;
            assign w_cii  = '0;
        end else begin : g_body
            assign w_left = w_val[g-1];
            assign w_civ  = w_cv[g-1];
            assign w_cid  = w_cd[g-1];
            assign w_cii  = w_ci[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_val[g];
        end else begin : g_mid
            assign w_right = w_val[g+1];
        end

        ple_cell #(
            .IDX (g),
            .PW  (PW),
            .IW  (IW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_pos     (w_pos),
            .i_count   (w_cnt),
            .i_value   (r_value),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_val     (w_val[g]),
            .i_c_valid (w_civ),
            .i_c_data  (w_cid),
            .i_c_idx   (w_cii),
            .o_c_valid (w_cv[g]),
            .o_c_data  (w_cd[g]),
            .o_c_idx   (w_ci[g])
        );
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("item count above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted word not taken into execution");

    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && (!r_out_valid || i_m_tready)) |=>
        (o_m_tvalid && (r_state == ST_IDLE)))
        else $error("finished result not moved to output");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + CW'(1)) && r_ok)
        else $error("insert did not grow the list by one");

endmodule

`default_nettype wire

### dv/positional_list_engine_checker.sv
`timescale 1ns / 1ps
// Checker for the positional list engine: watches both stream channels, keeps a shadow
// list, predicts each result word and compares it with the one the block returns.
// Depends on ple_pkg.
module positional_list_engine_checker #(
    parameter int LIST_CAP = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    input  wire                             i_s_tready,
    input  wire [ple_pkg::MODE_W-1:0]       i_s_tuser,
    input  wire [ple_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire                             i_m_tvalid,
    input  wire                             i_m_tready,
    input  wire [ple_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_list_len,
    output int                              o_checked,
    output int                              o_full_refusals
);
    import ple_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] rd;
        logic [FIDX_W-1:0] fidx;
        logic [CNT_W-1:0]  cnt;
    } t_outcome;

    logic [DATA_W-1:0] shadow [LIST_CAP];
    int                shadow_len = 0;
    t_outcome          outcome_q [$];

    function automatic t_outcome apply_list_op(input logic [MODE_W-1:0] op, input int pos,
                                               input logic [DATA_W-1:0] val);
        t_outcome res;
        res = '0;
        case (op)
            MODE_INSERT: begin
                if (pos <= shadow_len && shadow_len < LIST_CAP) begin
                    for (int i = shadow_len; i > pos; i--) shadow[i] = shadow[i-1];
                    shadow[pos] = val;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            MODE_GET: begin
                if (pos < shadow_len) begin
                    res.rd = shadow[pos];
                    res.ok = 1'b1;
                end
            end
            MODE_SET: begin
                if (pos < shadow_len) begin
                    shadow[pos] = val;
                    res.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (pos < shadow_len) begin
                    res.rd = shadow[pos];
                    for (int i = pos; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            MODE_FIND: begin
                for (int i = 0; i < shadow_len; i++) begin
                    if (shadow[i] == val) begin
                        res.fidx = i[FIDX_W-1:0];
                        res.ok   = 1'b1;
                        break;
                    end
                end
            end
            MODE_CLEAR: begin
                shadow_len = 0;
                res.ok     = 1'b1;
            end
            default: ;
        endcase
        res.cnt = shadow_len[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            shadow_len = 0;
            outcome_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.ok   = i_m_tdata[0];
                got.rd   = i_m_tdata[DATA_W:1];
                got.fidx = i_m_tdata[DATA_W+FIDX_W:DATA_W+1];
                got.cnt  = i_m_tdata[RES_W-1:DATA_W+FIDX_W+1];
                if (outcome_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result word ok=%0b value=%h found=%0d count=%0d",
                                 $realtime, got.ok, got.rd, got.fidx, got.cnt);
                end else begin
                    want = outcome_q.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: result %0d expected ok=%0b value=%h found=%0d cnt=%0d",
                                     $realtime, o_checked, want.ok, want.rd, want.fidx,
                                     want.cnt);
                            $display("    got ok=%0b value=%h found=%0d cnt=%0d",
                                     got.ok, got.rd, got.fidx, got.cnt);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == MODE_INSERT && shadow_len == LIST_CAP) o_full_refusals++;
                outcome_q.push_back(apply_list_op(i_s_tuser, int'(i_s_tdata[POS_W-1:0]),
                                                  i_s_tdata[POS_W+DATA_W-1:POS_W]));
            end
        end
        o_pending  = outcome_q.size();
        o_list_len = shadow_len;
    end

endmodule

### dv/positional_list_engine_tb.sv
`timescale 1ns / 1ps
// Testbench top for the positional list engine: clock, reset, operation stimulus and
// result back-pressure, with the verdict. Depends on ple_pkg, the engine and its checker.
module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int LIST_CAP     = 32;
    localparam int TOTAL_ITEMS  = 900;
    localparam int SETTLE_LIMIT = LIST_CAP + 16;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef enum int {FLAV_FILL, FLAV_MIX, FLAV_DRAIN, FLAV_NOISE} t_flavour;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic [MODE_W-1:0]      s_tuser    = '0;
    logic [IN_TDATA_W-1:0]  s_tdata    = '0;
    logic                   m_tready   = 1'b0;
    logic                   rx_steady  = 1'b0;
    logic                   tx_steady  = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int list_len;
    int checked;
    int full_refusals;
    int sent = 0;
    int rx_hold = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    positional_list_engine #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    positional_list_engine_checker #(
        .LIST_CAP (LIST_CAP)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tuser       (s_tuser),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_list_len      (list_len),
        .o_checked       (checked),
        .o_full_refusals (full_refusals)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // extremes and a few small values, so that searches hit often
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            3:       return '0;
            4, 5:    return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            rx_hold  <= pick_gap();
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= $urandom_range(0, 10);
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W-POS_W-DATA_W){1'b0}}, val, idx};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_flavour          flav;
        logic [MODE_W-1:0] op;
        logic [POS_W-1:0]  idx;
        int                round;
        int                span;
        int                roll;
        int                len;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list: failed search, every position out of range
        send_word(MODE_FIND,   6'd0,  32'h0000_0000);
        send_word(MODE_GET,    6'd0,  32'h0000_0000);
        send_word(MODE_REMOVE, 6'd0,  32'h0000_0000);
        send_word(MODE_SET,    6'd0,  32'h1234_5678);
        send_word(MODE_INSERT, 6'd1,  32'h0000_0001);
        // head, tail and middle inserts with extreme values
        send_word(MODE_INSERT, 6'd0,  32'h8000_0000);
        send_word(MODE_INSERT, 6'd1,  32'h7FFF_FFFF);
        send_word(MODE_INSERT, 6'd1,  32'h0000_0000);
        send_word(MODE_INSERT, 6'd0,  32'hFFFF_FFFF);
        send_word(MODE_INSERT, 6'd63, 32'h0000_0005);
        send_word(MODE_GET,    6'd3,  32'h0000_0000);
        send_word(MODE_GET,    6'd4,  32'h0000_0000);
        send_word(MODE_SET,    6'd2,  32'hAAAA_5555);
        send_word(MODE_FIND,   6'd0,  32'h7FFF_FFFF);
        send_word(MODE_FIND,   6'd0,  32'h0000_1234);
        // duplicate: search must give the first match
        send_word(MODE_INSERT, 6'd2,  32'hFFFF_FFFF);
        send_word(MODE_FIND,   6'd63, 32'hFFFF_FFFF);
        send_word(MODE_REMOVE, 6'd4,  32'h0000_0000);
        send_word(MODE_REMOVE, 6'd0,  32'h0000_0000);
        send_word(MODE_REMOVE, 6'd9,  32'h0000_0000);
        send_word(MODE_SPARE_LO, 6'd0, 32'h0000_0000);
        send_word(MODE_SPARE_HI, 6'd63, 32'hFFFF_FFFF);
        send_word(MODE_CLEAR,  6'd0,  32'h0000_0000);
        send_word(MODE_GET,    6'd0,  32'h0000_0000);
        send_word(MODE_FIND,   6'd0,  32'h0000_0000);

        round = 0;
        while (sent < TOTAL_ITEMS) begin
            flav = (round % 4 == 0) ? FLAV_FILL : t_flavour'($urandom_range(0, 3));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady <= ($urandom_range(0, 3) == 0);
            if (round == 0 || $urandom_range(0, 5) == 0) wait_drained();
            span = $urandom_range(30, 80);
            repeat (span) begin
                len  = list_len;
                roll = $urandom_range(0, 99);
                case (flav)
                    FLAV_FILL:
                        op = roll < 80 ? MODE_INSERT : roll < 88 ? MODE_GET :
                             roll < 94 ? MODE_FIND : MODE_SET;
                    FLAV_MIX:
                        op = roll < 30 ? MODE_INSERT : roll < 45 ? MODE_GET :
                             roll < 60 ? MODE_SET : roll < 80 ? MODE_REMOVE :
                             roll < 98 ? MODE_FIND : MODE_CLEAR;
                    FLAV_DRAIN:
                        op = roll < 60 ? MODE_REMOVE : roll < 75 ? MODE_INSERT :
                             roll < 85 ? MODE_GET : MODE_FIND;
                    default:
                        op = MODE_W'($urandom_range(0, 7));
                endcase
                roll = $urandom_range(0, 99);
                if (flav == FLAV_NOISE || roll >= 85)
                    idx = POS_W'($urandom_range(0, 63));
                else if (op == MODE_INSERT)
                    idx = POS_W'($urandom_range(0, len));
                else if (len > 0)
                    idx = POS_W'($urandom_range(0, len - 1));
                else
                    idx = POS_W'($urandom_range(0, 63));
                send_word(op, idx, pick_value());
            end
            round++;
        end

        wait_drained();
        repeat (SETTLE_LIMIT) @(negedge i_clk);
        $display("Run covered %0d operations over %0d random rounds; %0d results compared.",
                 sent, round, checked);
        $display("Inserts refused on a full list: %0d.", full_refusals);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("Timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine.sv
dv/positional_list_engine_checker.sv
dv/positional_list_engine_tb.sv
